@@ hw/rtl/nms_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the per-class NMS block.
// No dependencies.
package nms_pkg;

  localparam int MAX_DET = 64;
  localparam int IDX_W   = $clog2(MAX_DET);
  localparam int CNT_W   = IDX_W + 1;
  localparam logic [15:0] THR_RESET = 16'd29491;

  // controller -> datapath
  typedef struct packed {
    logic             ld_we;        // store incoming item at ld_addr
    logic [IDX_W-1:0] ld_addr;
    logic [IDX_W-1:0] sc_raddr;     // score/class read address (sort)
    logic             rd_sel_ord;   // box/score read address from order memory
    logic [IDX_W-1:0] ord_raddr;
    logic             ord_we;       // order[rank] <= i
    logic             si_load;      // latch score of entry i
    logic             rank_clr;
    logic             rank_acc;
    logic [IDX_W-1:0] i_idx;
    logic [IDX_W-1:0] j_idx;
    logic [IDX_W-1:0] sup_idx;
    logic             a_load;       // latch reference box
    logic             diff_load;
    logic             mul_load;
    logic             uni_load;
    logic             pp_load;
    logic             sup_try;      // mark sup_idx if same class and overlap test passes
    logic             sup_clr;
    logic             out_load;
    logic             ovf;
    logic [CNT_W-1:0] n_cnt;
  } nms_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sup_at;                   // suppressed flag at sup_idx
  } nms_stat_t;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] right;
    logic signed [15:0] bottom;
    logic        [15:0] score;
    logic        [7:0]  cls;
    logic               last;
    logic               ovf;
  } nms_res_t;

endpackage

@@ hw/rtl/nms_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces: detections in, kept boxes out.
// No dependencies.
interface nms_det_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] box_left;
  logic signed [15:0] box_top;
  logic signed [15:0] box_right;
  logic signed [15:0] box_bottom;
  logic        [15:0] score;
  logic        [7:0]  class_label;
  logic               final_item;
  modport source (output valid, box_left, box_top, box_right, box_bottom, score,
                  class_label, final_item, input ready);
  modport sink (input valid, box_left, box_top, box_right, box_bottom, score,
                class_label, final_item, output ready);
endinterface

interface nms_kept_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] kept_left;
  logic signed [15:0] kept_top;
  logic signed [15:0] kept_right;
  logic signed [15:0] kept_bottom;
  logic        [15:0] kept_score;
  logic        [7:0]  kept_class;
  logic               last_kept;
  logic               overflowed;
  modport source (output valid, kept_left, kept_top, kept_right, kept_bottom,
                  kept_score, kept_class, last_kept, overflowed, input ready);
  modport sink (input valid, kept_left, kept_top, kept_right, kept_bottom,
                kept_score, kept_class, last_kept, overflowed, output ready);
endinterface

@@ hw/rtl/nms_datapath.sv @@
`timescale 1ns / 1ps
// NMS datapath: detection memories, rank sort, overlap arithmetic, flags.
// Depends on nms_pkg.
module nms_datapath import nms_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  nms_cmd_t           cmd,
  output nms_stat_t          stat,
  input  logic signed [15:0] in_left,
  input  logic signed [15:0] in_top,
  input  logic signed [15:0] in_right,
  input  logic signed [15:0] in_bottom,
  input  logic        [15:0] in_score,
  input  logic        [7:0]  in_class,
  input  logic               cfg_we,
  input  logic        [15:0] cfg_wdata,
  output nms_res_t           res
);

  logic [63:0]      box_mem [0:MAX_DET-1];
  logic [23:0]      sc_mem  [0:MAX_DET-1];
  logic [IDX_W-1:0] ord_mem [0:MAX_DET-1];

  logic [63:0]      box_q;
  logic [23:0]      sc_q;
  logic [IDX_W-1:0] ord_q;
  logic [IDX_W-1:0] bs_raddr;

  logic [15:0]      thr_r;
  logic [15:0]      si_r;
  logic [IDX_W-1:0] rank_r;
  logic [MAX_DET-1:0] sup_r;

  logic signed [15:0] al_r, at_r, ar_r, ab_r;
  logic        [15:0] asc_r;
  logic        [7:0]  acls_r;

  logic signed [15:0] bl, bt, br, bb;
  logic [15:0]        iw_r, ih_r;
  logic signed [16:0] dxa_r, dya_r, dxb_r, dyb_r;
  logic               ceq_r, ceq2_r, ceq3_r, ceq4_r;
  logic [31:0]        inter_r, inter2_r, inter3_r;
  logic signed [33:0] area_a_r, area_b_r;
  logic signed [35:0] uni_r;
  logic [33:0]        plo_r;
  logic signed [34:0] phi_r;

  logic signed [16:0] iw_raw, ih_raw;
  logic signed [15:0] mn_r, mx_l, mn_b, mx_t;
  logic               greater;
  logic signed [53:0] prod, lhs;
  logic [MAX_DET-1:0] rem;
  logic               last;

  assign bs_raddr = cmd.rd_sel_ord ? ord_q : cmd.sc_raddr;

  always_ff @(posedge clk) begin
    if (cmd.ld_we) begin
      box_mem[cmd.ld_addr] <= {in_bottom, in_right, in_top, in_left};
      sc_mem[cmd.ld_addr]  <= {in_class, in_score};
    end
    if (cmd.ord_we) begin
      ord_mem[rank_r] <= cmd.i_idx;
    end
    box_q <= box_mem[bs_raddr];
    sc_q  <= sc_mem[bs_raddr];
    ord_q <= ord_mem[cmd.ord_raddr];
  end

  // stable descending rank: earlier equal scores count as ahead
  assign greater = (sc_q[15:0] > si_r) || ((sc_q[15:0] == si_r) && (cmd.j_idx < cmd.i_idx));

  assign bl = box_q[15:0];
  assign bt = box_q[31:16];
  assign br = box_q[47:32];
  assign bb = box_q[63:48];
  assign mn_r = (ar_r < br) ? ar_r : br;
  assign mx_l = (al_r > bl) ? al_r : bl;
  assign mn_b = (ab_r < bb) ? ab_r : bb;
  assign mx_t = (at_r > bt) ? at_r : bt;
  assign iw_raw = 17'(mn_r) - 17'(mx_l);
  assign ih_raw = 17'(mn_b) - 17'(mx_t);

  assign prod = 54'(phi_r) * 54'sd262144 + $signed({20'b0, plo_r});
  assign lhs  = $signed({6'b0, inter3_r, 16'b0});

  always_comb begin
    for (int k = 0; k < MAX_DET; k++) begin
      rem[k] = (k > int'(cmd.i_idx)) && (k < int'(cmd.n_cnt)) && !sup_r[k];
    end
    last = ~|rem;
  end

  assign stat.sup_at = sup_r[cmd.sup_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
      sup_r <= '0;
    end else begin
      if (cfg_we) thr_r <= cfg_wdata;
      if (cmd.sup_clr) begin
        sup_r <= '0;
      end else if (cmd.sup_try && ceq4_r && (lhs > prod)) begin
        sup_r[cmd.sup_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.si_load) si_r <= sc_q[15:0];
    if (cmd.rank_clr) begin
      rank_r <= '0;
    end else if (cmd.rank_acc && greater) begin
      rank_r <= rank_r + 1'b1;
    end
    if (cmd.a_load) begin
      al_r   <= bl;
      at_r   <= bt;
      ar_r   <= br;
      ab_r   <= bb;
      asc_r  <= sc_q[15:0];
      acls_r <= sc_q[23:16];
    end
    if (cmd.diff_load) begin
      iw_r  <= iw_raw[16] ? 16'd0 : iw_raw[15:0];
      ih_r  <= ih_raw[16] ? 16'd0 : ih_raw[15:0];
      dxa_r <= 17'(ar_r) - 17'(al_r);
      dya_r <= 17'(ab_r) - 17'(at_r);
      dxb_r <= 17'(br) - 17'(bl);
      dyb_r <= 17'(bb) - 17'(bt);
      ceq_r <= (sc_q[23:16] == acls_r);
    end
    if (cmd.mul_load) begin
      inter_r  <= iw_r * ih_r;
      area_a_r <= 34'(dxa_r) * 34'(dya_r);
      area_b_r <= 34'(dxb_r) * 34'(dyb_r);
      ceq2_r   <= ceq_r;
    end
    if (cmd.uni_load) begin
      uni_r    <= 36'(area_a_r) + 36'(area_b_r) - $signed({4'b0, inter_r});
      inter2_r <= inter_r;
      ceq3_r   <= ceq2_r;
    end
    if (cmd.pp_load) begin
      plo_r    <= thr_r * uni_r[17:0];
      phi_r    <= 35'($signed({1'b0, thr_r})) * 35'($signed(uni_r[35:18]));
      inter3_r <= inter2_r;
      ceq4_r   <= ceq3_r;
    end
    if (cmd.out_load) begin
      res.left   <= al_r;
      res.top    <= at_r;
      res.right  <= ar_r;
      res.bottom <= ab_r;
      res.score  <= asc_r;
      res.cls    <= acls_r;
      res.last   <= last;
      res.ovf    <= cmd.ovf;
    end
  end

endmodule

@@ hw/rtl/nms_ctrl.sv @@
`timescale 1ns / 1ps
// NMS controller: load, rank sort and suppression sequencing.
// Depends on nms_pkg.
module nms_ctrl import nms_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      in_final,
  output logic      out_valid,
  input  logic      out_ready,
  input  nms_stat_t stat,
  output nms_cmd_t  cmd
);

  localparam logic [3:0] S_LOAD = 4'd0,  S_SI   = 4'd1,  S_SIL  = 4'd2,  S_SJ  = 4'd3,
                         S_SW   = 4'd4,  S_NI   = 4'd5,  S_NA1  = 4'd6,  S_NA2 = 4'd7,
                         S_NJ   = 4'd8,  S_NB1  = 4'd9,  S_NB2  = 4'd10, S_NM1 = 4'd11,
                         S_NM2  = 4'd12, S_NM3  = 4'd13, S_NM4  = 4'd14, S_OUT = 4'd15;

  logic [3:0]       st_r, st_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, i_r, i_nxt, j_r, j_nxt;
  logic             ovf_r, ovf_nxt;

  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    i_nxt   = i_r;
    j_nxt   = j_r;
    ovf_nxt = ovf_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd         = '0;
    cmd.i_idx   = i_r[IDX_W-1:0];
    cmd.j_idx   = j_r[IDX_W-1:0];
    cmd.ld_addr = cnt_r[IDX_W-1:0];
    cmd.n_cnt   = cnt_r;
    cmd.ovf     = ovf_r;
    unique case (st_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (cnt_r < CNT_W'(MAX_DET)) begin
            cmd.ld_we = 1'b1;
            cnt_nxt   = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_final) begin
            i_nxt  = '0;
            st_nxt = S_SI;
          end
        end
      end
      S_SI: begin
        cmd.sc_raddr = i_r[IDX_W-1:0];
        st_nxt = S_SIL;
      end
      S_SIL: begin
        cmd.si_load  = 1'b1;
        cmd.rank_clr = 1'b1;
        cmd.sc_raddr = '0;
        j_nxt  = '0;
        st_nxt = S_SJ;
      end
      S_SJ: begin
        cmd.rank_acc = 1'b1;
        cmd.sc_raddr = IDX_W'(j_r + 1'b1);
        if (j_r == cnt_r - 1'b1) begin
          st_nxt = S_SW;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      S_SW: begin
        cmd.ord_we = 1'b1;
        if (i_r + 1'b1 == cnt_r) begin
          i_nxt  = '0;
          st_nxt = S_NI;
        end else begin
          i_nxt  = i_r + 1'b1;
          st_nxt = S_SI;
        end
      end
      S_NI: begin
        cmd.sup_idx = i_r[IDX_W-1:0];
        if (i_r == cnt_r) begin
          cmd.sup_clr = 1'b1;
          cnt_nxt = '0;
          ovf_nxt = 1'b0;
          st_nxt  = S_LOAD;
        end else if (stat.sup_at) begin
          i_nxt = i_r + 1'b1;
        end else begin
          cmd.ord_raddr = i_r[IDX_W-1:0];
          st_nxt = S_NA1;
        end
      end
      S_NA1: begin
        cmd.rd_sel_ord = 1'b1;
        st_nxt = S_NA2;
      end
      S_NA2: begin
        cmd.a_load = 1'b1;
        j_nxt  = i_r + 1'b1;
        st_nxt = S_NJ;
      end
      S_NJ: begin
        cmd.sup_idx = j_r[IDX_W-1:0];
        if (j_r == cnt_r) begin
          cmd.out_load = 1'b1;
          st_nxt = S_OUT;
        end else if (stat.sup_at) begin
          j_nxt = j_r + 1'b1;
        end else begin
          cmd.ord_raddr = j_r[IDX_W-1:0];
          st_nxt = S_NB1;
        end
      end
      S_NB1: begin
        cmd.rd_sel_ord = 1'b1;
        st_nxt = S_NB2;
      end
      S_NB2: begin
        cmd.diff_load = 1'b1;
        st_nxt = S_NM1;
      end
      S_NM1: begin
        cmd.mul_load = 1'b1;
        st_nxt = S_NM2;
      end
      S_NM2: begin
        cmd.uni_load = 1'b1;
        st_nxt = S_NM3;
      end
      S_NM3: begin
        cmd.pp_load = 1'b1;
        st_nxt = S_NM4;
      end
      S_NM4: begin
        cmd.sup_idx = j_r[IDX_W-1:0];
        cmd.sup_try = 1'b1;
        j_nxt  = j_r + 1'b1;
        st_nxt = S_NJ;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          i_nxt  = i_r + 1'b1;
          st_nxt = S_NI;
        end
      end
      default: st_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_LOAD;
      cnt_r <= '0;
      i_r   <= '0;
      j_r   <= '0;
      ovf_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      i_r   <= i_nxt;
      j_r   <= j_nxt;
      ovf_r <= ovf_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_DET)) else $error("fill count past capacity");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("load and emit at once");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_set_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SI) |-> (cnt_r != '0)) else $error("sort on empty set");
`endif

endmodule

@@ hw/rtl/per_class_non_max_suppression.sv @@
`timescale 1ns / 1ps
// Top level of the per-class greedy NMS block.
// Depends on nms_pkg, nms_if, nms_ctrl, nms_datapath.
//
//  port    dir  protocol     carries
//  in_ch   in   valid/ready  one detection (box, score, class, final mark)
//  out_ch  out  valid/ready  one kept box (last mark, overflow mark)
//  cfg_*   in   write only   iou_threshold, Q0.16
//
// Items are taken one per cycle while loading. After the final item the set of
// N entries is rank sorted, one score compare a cycle on the score memory read
// port; then each kept box is compared with every later unsuppressed box of
// any class (memory reads and a 4-stage multiply chain), suppressed entries are
// skipped, each result holds S_OUT until taken, and a closing step in S_NI
// returns the block to loading.
// Reset is synchronous, active low; memories are not cleared.
// No item is taken while a set is being sorted or emitted.
module per_class_non_max_suppression import nms_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  nms_det_if.sink     in_ch,
  nms_kept_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  nms_cmd_t  cmd;
  nms_stat_t stat;
  nms_res_t  res;

  nms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_final  (in_ch.final_item),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  nms_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_left   (in_ch.box_left),
    .in_top    (in_ch.box_top),
    .in_right  (in_ch.box_right),
    .in_bottom (in_ch.box_bottom),
    .in_score  (in_ch.score),
    .in_class  (in_ch.class_label),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res       (res)
  );

  // result register lives in the datapath
  assign out_ch.kept_left   = res.left;
  assign out_ch.kept_top    = res.top;
  assign out_ch.kept_right  = res.right;
  assign out_ch.kept_bottom = res.bottom;
  assign out_ch.kept_score  = res.score;
  assign out_ch.kept_class  = res.cls;
  assign out_ch.last_kept   = res.last;
  assign out_ch.overflowed  = res.ovf;

endmodule

@@ test/per_class_non_max_suppression_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the per-class greedy NMS block.
// Depends on nms_pkg, nms_if and the per_class_non_max_suppression RTL.
module per_class_non_max_suppression_tb;
  import nms_pkg::*;

  typedef struct {
    logic signed [15:0] left, top, right, bottom;
    logic [15:0] score;
    logic [7:0]  cls;
    logic        fin;
  } det_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  nms_det_if  det_ch ();
  nms_kept_if kept_ch ();

  per_class_non_max_suppression dut (
    .clk(clk), .rst_n(rst_n), .in_ch(det_ch.sink), .out_ch(kept_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // model state
  det_t       set_store[$];
  logic       set_ovf;
  logic [15:0] thr;
  nms_res_t   kept_expect[$];
  det_t       pending[$];

  int send_idle_pct, recv_idle_pct;
  int errors, kept_seen, det_sent, sets_done;

  // overlap test on exact signed products
  function automatic bit over_thr(det_t a, det_t b, logic [15:0] t);
    longint iw, ih, inter, aa, ab, un;
    iw = ((a.right < b.right) ? a.right : b.right) - ((a.left > b.left) ? a.left : b.left);
    ih = ((a.bottom < b.bottom) ? a.bottom : b.bottom) - ((a.top > b.top) ? a.top : b.top);
    if (iw < 0) iw = 0;
    if (ih < 0) ih = 0;
    inter = iw * ih;
    aa = (longint'(a.right) - a.left) * (longint'(a.bottom) - a.top);
    ab = (longint'(b.right) - b.left) * (longint'(b.bottom) - b.top);
    un = aa + ab - inter;
    return inter * 65536 > longint'({1'b0, t}) * un;
  endfunction

  // accept one detection; on final mark predict the kept list
  task automatic predict_nms(det_t d);
    int order[$];
    bit sup[64];
    int n, pos;
    nms_res_t r;
    if (set_store.size() < MAX_DET) set_store.insert(set_store.size(), d);
    else set_ovf = 1'b1;
    if (!d.fin) return;
    n = set_store.size();
    for (int i = 0; i < n; i++) begin
      pos = order.size();
      while (pos > 0 && set_store[order[pos-1]].score < set_store[i].score) pos--;
      order.insert(pos, i);
    end
    for (int i = 0; i < n; i++) sup[i] = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (sup[i]) continue;
      for (int j = i + 1; j < n; j++)
        if (!sup[j] && set_store[order[i]].cls == set_store[order[j]].cls &&
            over_thr(set_store[order[i]], set_store[order[j]], thr))
          sup[j] = 1'b1;
      r.left = set_store[order[i]].left;     r.top = set_store[order[i]].top;
      r.right = set_store[order[i]].right;   r.bottom = set_store[order[i]].bottom;
      r.score = set_store[order[i]].score;   r.cls = set_store[order[i]].cls;
      r.last = 1'b0;                         r.ovf = set_ovf;
      kept_expect.insert(kept_expect.size(), r);
    end
    kept_expect[kept_expect.size()-1].last = 1'b1;
    set_store.delete();
    set_ovf = 1'b0;
    sets_done++;
  endtask

  // driver: one nonblocking write per signal per edge
  always @(posedge clk) begin
    if (!rst_n) begin
      det_ch.valid <= 1'b0;
    end else begin
      automatic bit done = det_ch.valid && det_ch.ready;
      if (done) begin
        predict_nms(pending.pop_front());
        det_sent++;
      end
      if ((!det_ch.valid || done) && pending.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        det_ch.valid       <= 1'b1;
        det_ch.box_left    <= pending[0].left;
        det_ch.box_top     <= pending[0].top;
        det_ch.box_right   <= pending[0].right;
        det_ch.box_bottom  <= pending[0].bottom;
        det_ch.score       <= pending[0].score;
        det_ch.class_label <= pending[0].cls;
        det_ch.final_item  <= pending[0].fin;
      end else if (done) begin
        det_ch.valid <= 1'b0;
      end
    end
  end

  // monitor plus receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      kept_ch.ready <= 1'b0;
    end else begin
      kept_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (kept_ch.valid && kept_ch.ready) begin
        kept_seen++;
        if (kept_expect.size() == 0) begin
          $error("unexpected kept box, left %0d", kept_ch.kept_left);
          errors++;
        end else begin
          automatic nms_res_t e = kept_expect.pop_front();
          if (kept_ch.kept_left !== e.left) begin
            $error("kept_left exp %0d got %0d", e.left, kept_ch.kept_left); errors++; end
          if (kept_ch.kept_top !== e.top) begin
            $error("kept_top exp %0d got %0d", e.top, kept_ch.kept_top); errors++; end
          if (kept_ch.kept_right !== e.right) begin
            $error("kept_right exp %0d got %0d", e.right, kept_ch.kept_right); errors++; end
          if (kept_ch.kept_bottom !== e.bottom) begin
            $error("kept_bottom exp %0d got %0d", e.bottom, kept_ch.kept_bottom); errors++; end
          if (kept_ch.kept_score !== e.score) begin
            $error("kept_score exp %0d got %0d", e.score, kept_ch.kept_score); errors++; end
          if (kept_ch.kept_class !== e.cls) begin
            $error("kept_class exp %0d got %0d", e.cls, kept_ch.kept_class); errors++; end
          if (kept_ch.last_kept !== e.last) begin
            $error("last_kept exp %0b got %0b", e.last, kept_ch.last_kept); errors++; end
          if (kept_ch.overflowed !== e.ovf) begin
            $error("overflowed exp %0b got %0b", e.ovf, kept_ch.overflowed); errors++; end
        end
      end
    end
  end

  // random detection; mostly clustered boxes in few classes so IoU matters
  function automatic det_t rand_det(bit fin);
    det_t d;
    int cx, cy, w, h;
    if ($urandom_range(9) == 0) begin
      d.left = 16'($urandom); d.top = 16'($urandom);
      d.right = 16'($urandom); d.bottom = 16'($urandom);
      d.cls = 8'($urandom);
    end else begin
      cx = $urandom_range(400) - 200; cy = $urandom_range(400) - 200;
      w = $urandom_range(300); h = $urandom_range(300);
      d.left = 16'(cx - w); d.right = 16'(cx + w + $urandom_range(40) - 10);
      d.top = 16'(cy - h);  d.bottom = 16'(cy + h + $urandom_range(40) - 10);
      d.cls = 8'($urandom_range(2));
    end
    d.score = ($urandom_range(3) == 0) ? 16'($urandom_range(3) * 21845) : 16'($urandom);
    d.fin = fin;
    return d;
  endfunction

  task automatic queue_det(det_t d);
    pending.insert(pending.size(), d);
  endtask

  task automatic push_set(int n);
    for (int i = 0; i < n; i++) queue_det(rand_det(i == n - 1));
  endtask

  function automatic det_t mk(int l, int t, int r, int b, int s, int c, bit f);
    det_t d;
    d.left = 16'(l); d.top = 16'(t); d.right = 16'(r); d.bottom = 16'(b);
    d.score = 16'(s); d.cls = 8'(c); d.fin = f;
    return d;
  endfunction

  // wait for all results, then let the block go quiet before a register write
  task automatic drain();
    while (pending.size() > 0 || det_ch.valid || kept_expect.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_thr(logic [15:0] v);
    cfg_we <= 1'b1; cfg_wdata <= v; thr = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    det_ch.valid = 1'b0; det_ch.box_left = '0; det_ch.box_top = '0;
    det_ch.box_right = '0; det_ch.box_bottom = '0; det_ch.score = '0;
    det_ch.class_label = '0; det_ch.final_item = 1'b0; kept_ch.ready = 1'b0;
    thr = THR_RESET; set_ovf = 1'b0;
    errors = 0; kept_seen = 0; det_sent = 0; sets_done = 0;
    send_idle_pct = 16; recv_idle_pct = 66;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed at reset threshold: lone box, field extremes, tie order,
    // same-class suppression, other class kept, inverted and degenerate boxes
    queue_det(mk(-32768, -32768, 32767, 32767, 65535, 255, 1));
    queue_det(mk(0, 0, 100, 100, 500, 1, 0));
    queue_det(mk(5, 5, 100, 100, 500, 1, 0));
    queue_det(mk(5, 5, 100, 100, 900, 2, 0));
    queue_det(mk(100, 100, 0, 0, 0, 1, 0));
    queue_det(mk(7, 7, 7, 7, 700, 1, 0));
    queue_det(mk(32767, 32767, -32768, -32768, 1, 0, 1));
    drain();
    // threshold zero: any positive overlap suppresses
    write_thr(16'd0);
    queue_det(mk(0, 0, 10, 10, 10, 3, 0));
    queue_det(mk(9, 9, 20, 20, 5, 3, 1));
    drain();
    // full threshold; then an over-capacity set with a dropped final item
    write_thr(16'hFFFF);
    queue_det(mk(0, 0, 10, 10, 10, 3, 0));
    queue_det(mk(0, 0, 10, 10, 5, 3, 1));
    drain();
    write_thr(THR_RESET);
    push_set(MAX_DET + 2);
    drain();

    // random sets under three idle profiles and changing thresholds
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 66 : 0;
      recv_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 16 : 0;
      write_thr((ph == 2) ? 16'($urandom) : 16'($urandom_range(16384, 49152)));
      for (int k = 0; k < 12; k++)
        push_set(($urandom_range(9) == 0) ? $urandom_range(40, 64) : $urandom_range(1, 8));
      drain();
    end

    $display("covered %0d detections in %0d sets, %0d kept boxes checked",
             det_sent, sets_done, kept_seen);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
